[src/fdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_pkg: shared constants and types of the floppy track controller
// Bus register addresses, request codes, disk geometry and the access
// record passed from the controller state to the disk store.
// ----------------------------------------------------------------------------
package fdc_pkg;

   // Disk geometry
   localparam int TRACK_BYTES = 6656;
   localparam int NUM_TRACKS  = 40;
   localparam int STORE_BYTES = TRACK_BYTES * NUM_TRACKS;

   localparam int POS_W  = $clog2(TRACK_BYTES);
   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam int HEAD_W = 7;
   localparam int TRK_W  = HEAD_W - 1;
   localparam int IMG_W  = 19;

   localparam logic [HEAD_W-1:0] HEAD_MAX = 7'd79;

   localparam logic [7:0] STEP_IDLE_DATA = 8'h80;
   localparam logic [7:0] ERASED_BYTE    = 8'hFF;

   // Request codes
   localparam logic [1:0] REQ_CPU_RD = 2'd0;
   localparam logic [1:0] REQ_CPU_WR = 2'd1;
   localparam logic [1:0] REQ_IMG_WR = 2'd2;
   localparam logic [1:0] REQ_IMG_RD = 2'd3;

   // Bus register addresses
   localparam logic [15:0] ADDR_WMODE_OFF_A = 16'h1128;
   localparam logic [15:0] ADDR_WPROT       = 16'h1140;
   localparam logic [15:0] ADDR_PHASE0      = 16'h1181;
   localparam logic [15:0] ADDR_PHASE1      = 16'h1183;
   localparam logic [15:0] ADDR_PHASE2      = 16'h1185;
   localparam logic [15:0] ADDR_PHASE3      = 16'h1187;
   localparam logic [15:0] ADDR_MOTOR_OFF   = 16'h1188;
   localparam logic [15:0] ADDR_MOTOR_ON    = 16'h118A;
   localparam logic [15:0] ADDR_SHIFT       = 16'h118C;
   localparam logic [15:0] ADDR_LATCH       = 16'h118D;
   localparam logic [15:0] ADDR_WMODE_OFF_B = 16'h118E;
   localparam logic [15:0] ADDR_WMODE_ON    = 16'h118F;

   // One request's effect on the disk store and on the response
   typedef struct packed {
      logic              mem_we;
      logic              mem_re;
      logic [ADDR_W-1:0] mem_addr;
      logic [7:0]        mem_wdata;
      logic              use_mem;
      logic [7:0]        fixed_data;
      logic              dirty;
   } access_type;

endpackage

[src/fdc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_ctrl: controller state of the floppy track controller
// Holds mode, motor, latch, head and position state, decodes one request
// per cycle while accept is high and issues the matching disk store access.
// ----------------------------------------------------------------------------
module fdc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [1:0]                req_type,
   input  logic [15:0]               req_addr,
   input  logic [7:0]                req_write_data,
   input  logic [fdc_pkg::IMG_W-1:0] req_image_addr,
   output fdc_pkg::access_type       access
);
   import fdc_pkg::*;

   logic              write_mode_ff, write_mode_in;
   logic              motor_ff, motor_in;
   logic [7:0]        latched_ff, latched_in;
   logic              latch_full_ff, latch_full_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [1:0]        last_phase_ff, last_phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              dirty_ff, dirty_in;

   logic [TRK_W-1:0]  trk_sel;
   logic [POS_W-1:0]  pos_eff;
   logic [POS_W-1:0]  pos_adv;
   logic [ADDR_W-1:0] cell_addr;
   logic [1:0]        phase;
   logic              is_step;

   // Current cell: clamp track, wrap stale position
   always_comb begin
      trk_sel = head_ff[HEAD_W-1:1];
      if (int'(trk_sel) >= NUM_TRACKS) begin
         trk_sel = TRK_W'(NUM_TRACKS - 1);
      end
      pos_eff = (int'(pos_ff) >= TRACK_BYTES) ? '0 : pos_ff;
      pos_adv = (pos_eff == POS_W'(TRACK_BYTES - 1)) ? '0 : pos_eff + 1'b1;
      cell_addr = ADDR_W'(trk_sel) * ADDR_W'(TRACK_BYTES) + ADDR_W'(pos_eff);
   end

   always_comb begin
      write_mode_in = write_mode_ff;
      motor_in      = motor_ff;
      latched_in    = latched_ff;
      latch_full_in = latch_full_ff;
      head_in       = head_ff;
      last_phase_in = last_phase_ff;
      pos_in        = pos_ff;
      dirty_in      = dirty_ff;
      phase         = 2'd0;
      is_step       = 1'b0;

      access.mem_we     = 1'b0;
      access.mem_re     = 1'b0;
      access.mem_addr   = cell_addr;
      access.mem_wdata  = latched_ff;
      access.use_mem    = 1'b0;
      access.fixed_data = 8'd0;

      unique case (req_type)
         REQ_CPU_RD: begin
            unique case (req_addr)
               ADDR_WMODE_OFF_A, ADDR_WMODE_OFF_B: write_mode_in = 1'b0;
               ADDR_WPROT: access.fixed_data = 8'd0;
               ADDR_PHASE0: begin phase = 2'd0; is_step = 1'b1; end
               ADDR_PHASE1: begin phase = 2'd1; is_step = 1'b1; end
               ADDR_PHASE2: begin phase = 2'd2; is_step = 1'b1; end
               ADDR_PHASE3: begin phase = 2'd3; is_step = 1'b1; end
               ADDR_MOTOR_OFF: begin
                  motor_in      = 1'b0;
                  write_mode_in = 1'b0;
                  pos_in        = '0;
               end
               ADDR_MOTOR_ON: motor_in = 1'b1;
               ADDR_SHIFT: begin
                  if (write_mode_ff) begin
                     if (latch_full_ff) begin
                        access.mem_we     = accept;
                        access.fixed_data = latched_ff;
                        pos_in            = pos_adv;
                        latch_full_in     = 1'b0;
                        dirty_in          = 1'b1;
                     end
                  end else begin
                     access.mem_re  = accept;
                     access.use_mem = 1'b1;
                     pos_in         = pos_adv;
                  end
               end
               default: ;
            endcase
         end
         REQ_CPU_WR: begin
            if (req_addr == ADDR_LATCH) begin
               if (write_mode_ff) begin
                  latched_in    = req_write_data;
                  latch_full_in = 1'b1;
               end
            end else if (req_addr == ADDR_WMODE_ON) begin
               write_mode_in = 1'b1;
            end
         end
         REQ_IMG_WR: begin
            access.mem_addr  = ADDR_W'(req_image_addr);
            access.mem_wdata = req_write_data;
            access.mem_we    = accept && (int'(req_image_addr) < STORE_BYTES);
         end
         REQ_IMG_RD: begin
            access.mem_addr = ADDR_W'(req_image_addr);
            access.use_mem  = int'(req_image_addr) < STORE_BYTES;
            access.mem_re   = accept && access.use_mem;
         end
         default: ;
      endcase

      // Step with the motor on: move up when the new phase follows the last one, else down
      if (is_step) begin
         if (!motor_ff) begin
            access.fixed_data = STEP_IDLE_DATA;
         end else begin
            if (last_phase_ff == phase - 2'd1) begin
               if (head_ff < HEAD_MAX) head_in = head_ff + 1'b1;
            end else begin
               if (head_ff != '0) head_in = head_ff - 1'b1;
            end
            last_phase_in = phase;
            pos_in        = '0;
         end
      end

      access.dirty = dirty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_mode_ff <= 1'b0;
         motor_ff      <= 1'b0;
         latched_ff    <= 8'd0;
         latch_full_ff <= 1'b0;
         head_ff       <= '0;
         last_phase_ff <= 2'd0;
         pos_ff        <= '0;
         dirty_ff      <= 1'b0;
      end else if (accept) begin
         write_mode_ff <= write_mode_in;
         motor_ff      <= motor_in;
         latched_ff    <= latched_in;
         latch_full_ff <= latch_full_in;
         head_ff       <= head_in;
         last_phase_ff <= last_phase_in;
         pos_ff        <= pos_in;
         dirty_ff      <= dirty_in;
      end
   end

endmodule

[src/floppy_stepper_track_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floppy_stepper_track_controller: stepper, motor and track shift controller
// CPU bus register accesses step the head, switch the motor and modes, and
// shift bytes to or from the current track; a host port loads and reads
// the disk store directly.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type, req_addr,
//                                            req_write_data, req_image_addr
//   rsp      out        rsp_valid/rsp_stall  rsp_read_data, rsp_disk_dirty
//
// One request per cycle, sustained while req_stall is low. The accepting
// edge captures the store read data and the decoded payload in the read
// stage; the response register, which drives rsp_valid, loads from the read
// stage when it advances. After reset a clearing pass writes 0xFF to every
// byte of the disk store (STORE_BYTES, 266240 bytes), one byte a cycle;
// req_stall stays high throughout. A stalled response holds its register and
// the store read stage; outside the clearing pass, req_stall rises only when
// both are full and rsp_stall is high.
//
module floppy_stepper_track_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [15:0]               req_addr,
   input  logic [7:0]                req_write_data,
   input  logic [fdc_pkg::IMG_W-1:0] req_image_addr,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_read_data,
   output logic                      rsp_disk_dirty
);
   import fdc_pkg::*;

   access_type        access;
   logic              accept;
   logic              advance;

   // Clearing pass after reset
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clear_cnt_ff, clear_cnt_in;

   // Disk store
   logic [7:0]        store_mem [STORE_BYTES];
   logic [7:0]        mem_q_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]        mem_wdata;

   // Read stage: request waits here for the store read data
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_use_mem_ff;
   logic [7:0]        s1_fixed_ff;
   logic              s1_dirty_ff;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff;
   logic              rsp_dirty_ff;

   fdc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_type       (req_type),
      .req_addr       (req_addr),
      .req_write_data (req_write_data),
      .req_image_addr (req_image_addr),
      .access         (access)
   );

   // Handshake: move read stage forward when response slot frees up
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing_ff || (s1_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Sweep the store with erased bytes, then release the request side
   always_comb begin
      clear_cnt_in = clear_cnt_ff;
      clearing_in  = clearing_ff;
      if (clearing_ff) begin
         if (clear_cnt_ff == ADDR_W'(STORE_BYTES - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clear_cnt_in = clear_cnt_ff + 1'b1;
         end
      end
   end

   // Store port: the clearing pass owns it until done
   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_addr  = clear_cnt_ff;
         mem_wdata = ERASED_BYTE;
      end else begin
         mem_we    = access.mem_we;
         mem_addr  = access.mem_addr;
         mem_wdata = access.mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      // Read only on accept so the data holds while the stage is stalled
      if (access.mem_re && !clearing_ff) begin
         mem_q_ff <= store_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_cnt_ff <= clear_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_use_mem_ff <= access.use_mem;
         s1_fixed_ff   <= access.fixed_data;
         s1_dirty_ff   <= access.dirty;
      end
      if (advance) begin
         rsp_data_ff  <= s1_use_mem_ff ? mem_q_ff : s1_fixed_ff;
         rsp_dirty_ff <= s1_dirty_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_disk_dirty = rsp_dirty_ff;

endmodule

[tb/tb_floppy_stepper_track_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_floppy_stepper_track_controller: self-checking bench for the track controller
// Drives CPU register accesses and host disk image accesses through the
// request channel. A behavioral model of the stepper, latch and disk store
// predicts every response. A short directed table comes first, then random
// bus traffic built from stepping, write, read, host, motor and noise
// sequences, then a short run of shifts without idling. Both channels idle
// and stall at random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_floppy_stepper_track_controller;
   import fdc_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int HOLD_CYCLES  = 120;
   localparam int RANDOM_ITEMS = 400;
   localparam int TAIL_SHIFTS  = 32;
   localparam int NUM_ROWS     = 25;

   // One directed row; typed rows carry their response, others use the model
   typedef struct packed {
      logic [1:0]       kind;
      logic [15:0]      addr;
      logic [7:0]       data;
      logic [IMG_W-1:0] iaddr;
      logic             typed;
      logic [7:0]       exp_data;
      logic             exp_dirty;
   } directed_row_type;

   typedef struct {
      logic [7:0] read_data;
      logic       disk_dirty;
   } bus_reply_type;

   typedef enum {
      SEQ_STEP, SEQ_WRITE, SEQ_READ, SEQ_HOST, SEQ_MOTOR, SEQ_NOISE
   } traffic_kind_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_type;
   logic [15:0]          req_addr;
   logic [7:0]           req_write_data;
   logic [IMG_W-1:0]     req_image_addr;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [7:0]           rsp_read_data;
   logic                 rsp_disk_dirty;

   // Model state of the drive
   logic                 wr_mode;
   logic                 spindle_run;
   logic [7:0]           latch_data;
   logic                 latch_loaded;
   logic [HEAD_W-1:0]    head_pos;
   logic [1:0]           phase_held;
   logic [POS_W-1:0]     byte_pos;
   logic                 disk_written;
   logic [7:0]           disk_image [STORE_BYTES];

   bus_reply_type        pending_replies [$];
   int                   mismatch_count;
   int                   items_sent;
   int                   cycle_count;
   bit                   idle_on;
   bit                   hold_request;

   logic [15:0] reg_map [12] = '{
      ADDR_WMODE_OFF_A, ADDR_WPROT, ADDR_PHASE0, ADDR_PHASE1, ADDR_PHASE2,
      ADDR_PHASE3, ADDR_MOTOR_OFF, ADDR_MOTOR_ON, ADDR_SHIFT, ADDR_LATCH,
      ADDR_WMODE_OFF_B, ADDR_WMODE_ON
   };

   logic [15:0] phase_addr [4] = '{ADDR_PHASE0, ADDR_PHASE1, ADDR_PHASE2, ADDR_PHASE3};

   // Directed table: erased reads, motor-off step, host range edges, a full
   // stepping cycle, latch and shift in write mode, and every mode switch but ADDR_WMODE_OFF_B
   directed_row_type directed_rows [NUM_ROWS] = '{
      // erased byte at track 0, position 0 right after reset
      '{REQ_CPU_RD, ADDR_SHIFT,     8'h00, 19'd0,        1'b1, ERASED_BYTE,    1'b0},
      // step with the motor off answers the idle pattern and moves nothing
      '{REQ_CPU_RD, ADDR_PHASE1,    8'h00, 19'd0,        1'b1, STEP_IDLE_DATA, 1'b0},
      // host accesses past the end of the store
      '{REQ_IMG_RD, 16'hFFFF,       8'hFF, 19'(STORE_BYTES), 1'b1, 8'h00,      1'b0},
      '{REQ_IMG_RD, 16'h0000,       8'h00, 19'h7FFFF,    1'b1, 8'h00,          1'b0},
      '{REQ_IMG_WR, 16'h0000,       8'hAA, 19'h7FFFF,    1'b1, 8'h00,          1'b0},
      '{REQ_IMG_WR, 16'h0000,       8'h00, 19'd0,        1'b1, 8'h00,          1'b0},
      '{REQ_IMG_WR, 16'h0000,       8'h5A, 19'(STORE_BYTES - 1), 1'b1, 8'h00,  1'b0},
      '{REQ_IMG_RD, 16'h0000,       8'h00, 19'(STORE_BYTES - 1), 1'b1, 8'h5A,  1'b0},
      '{REQ_CPU_RD, ADDR_SHIFT,     8'h00, 19'd0,        1'b0, 8'h00,          1'b0},
      '{REQ_CPU_RD, ADDR_MOTOR_ON,  8'h00, 19'd0,        1'b1, 8'h00,          1'b0},
      // same phase again steps down, clamped at half-track 0
      '{REQ_CPU_RD, ADDR_PHASE0,    8'h00, 19'd0,        1'b0, 8'h00,          1'b0},
      '{REQ_CPU_RD, ADDR_PHASE1,    8'h00, 19'd0,        1'b0, 8'h00,          1'b0},
      '{REQ_CPU_RD, ADDR_PHASE2,    8'h00, 19'd0,        1'b0, 8'h00,          1'b0},
      '{REQ_CPU_RD, ADDR_PHASE3,    8'h00, 19'd0,        1'b0, 8'h00,          1'b0},
      '{REQ_CPU_RD, ADDR_PHASE0,    8'h00, 19'd0,        1'b0, 8'h00,          1'b0},
      '{REQ_CPU_RD, ADDR_PHASE3,    8'h00, 19'd0,        1'b0, 8'h00,          1'b0},
      '{REQ_CPU_WR, ADDR_WMODE_ON,  8'h00, 19'd0,        1'b1, 8'h00,          1'b0},
      '{REQ_CPU_WR, ADDR_LATCH,     8'hFF, 19'd0,        1'b1, 8'h00,          1'b0},
      '{REQ_CPU_RD, ADDR_SHIFT,     8'h00, 19'd0,        1'b0, 8'h00,          1'b0},
      // write mode with an empty latch shifts nothing
      '{REQ_CPU_RD, ADDR_SHIFT,     8'h00, 19'd0,        1'b1, 8'h00,          1'b1},
      '{REQ_CPU_RD, ADDR_WPROT,     8'h00, 19'd0,        1'b1, 8'h00,          1'b1},
      '{REQ_CPU_RD, ADDR_WMODE_OFF_A, 8'h00, 19'd0,      1'b1, 8'h00,          1'b1},
      // latch write in read mode is dropped
      '{REQ_CPU_WR, ADDR_LATCH,     8'h11, 19'd0,        1'b1, 8'h00,          1'b1},
      '{REQ_CPU_RD, ADDR_MOTOR_OFF, 8'h00, 19'd0,        1'b1, 8'h00,          1'b1},
      '{REQ_CPU_WR, 16'hFFFF,       8'hFF, 19'd0,        1'b1, 8'h00,          1'b1}
   };

   floppy_stepper_track_controller uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_addr       (req_addr),
      .req_write_data (req_write_data),
      .req_image_addr (req_image_addr),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_disk_dirty (rsp_disk_dirty)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Move the head one half-track; up when the new phase follows the last one
   function automatic logic [7:0] step_head(input logic [1:0] phase);
      if (!spindle_run) return STEP_IDLE_DATA;
      if (phase_held == phase + 2'd3) begin
         if (head_pos < HEAD_MAX) head_pos = head_pos + 1'b1;
      end else if (head_pos != '0) begin
         head_pos = head_pos - 1'b1;
      end
      phase_held = phase;
      byte_pos   = '0;
      return 8'h00;
   endfunction

   // Apply one request to the model and return the byte it answers
   function automatic logic [7:0] predict_bus_reply(input logic [1:0] kind,
                                                    input logic [15:0] a,
                                                    input logic [7:0] wd,
                                                    input logic [IMG_W-1:0] ia);
      logic [7:0]  rd;
      int unsigned trk;
      int unsigned idx;
      rd = 8'h00;
      case (kind)
         REQ_CPU_RD: begin
            case (a)
               ADDR_WMODE_OFF_A, ADDR_WMODE_OFF_B: wr_mode = 1'b0;
               ADDR_PHASE0: rd = step_head(2'd0);
               ADDR_PHASE1: rd = step_head(2'd1);
               ADDR_PHASE2: rd = step_head(2'd2);
               ADDR_PHASE3: rd = step_head(2'd3);
               ADDR_MOTOR_OFF: begin
                  spindle_run = 1'b0;
                  wr_mode     = 1'b0;
                  byte_pos    = '0;
               end
               ADDR_MOTOR_ON: spindle_run = 1'b1;
               ADDR_SHIFT: begin
                  // write mode with an empty latch leaves everything alone
                  if (!wr_mode || latch_loaded) begin
                     trk = int'(head_pos) >> 1;
                     if (trk >= NUM_TRACKS) trk = NUM_TRACKS - 1;
                     if (byte_pos >= TRACK_BYTES) byte_pos = '0;
                     idx = trk * TRACK_BYTES + int'(byte_pos);
                     if (wr_mode) begin
                        disk_image[idx] = latch_data;
                        latch_loaded    = 1'b0;
                        disk_written    = 1'b1;
                        rd              = latch_data;
                     end else begin
                        rd = disk_image[idx];
                     end
                     byte_pos = (int'(byte_pos) == TRACK_BYTES - 1) ? '0 : byte_pos + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         REQ_CPU_WR: begin
            if (a == ADDR_LATCH) begin
               if (wr_mode) begin
                  latch_data   = wd;
                  latch_loaded = 1'b1;
               end
            end else if (a == ADDR_WMODE_ON) begin
               wr_mode = 1'b1;
            end
         end
         REQ_IMG_WR: if (ia < STORE_BYTES) disk_image[ia] = wd;
         default:    if (ia < STORE_BYTES) rd = disk_image[ia];
      endcase
      return rd;
   endfunction

   // Offer one request, hold it until accepted, then record its response
   task automatic send_request(input logic [1:0] kind, input logic [15:0] a,
                               input logic [7:0] wd, input logic [IMG_W-1:0] ia,
                               input logic typed = 1'b0, input logic [7:0] exp_data = '0,
                               input logic exp_dirty = 1'b0);
      logic [7:0]    rd;
      bus_reply_type reply;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_addr       <= a;
      req_write_data <= wd;
      req_image_addr <= ia;
      do @(posedge clock); while (req_stall);
      rd = predict_bus_reply(kind, a, wd, ia);
      if (typed) reply = '{exp_data, exp_dirty};
      else       reply = '{rd, disk_written};
      pending_replies.push_back(reply);
      items_sent++;
   endtask

   // CPU accesses with random don't-care fields
   task automatic bus_read(input logic [15:0] a);
      send_request(REQ_CPU_RD, a, 8'($urandom), IMG_W'($urandom));
   endtask

   task automatic bus_write(input logic [15:0] a, input logic [7:0] wd);
      send_request(REQ_CPU_WR, a, wd, IMG_W'($urandom));
   endtask

   // Response stall: random short bursts, plus one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall    <= 1'b0;
            hold_request  = 1'b0;
            @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
   end

   // Compare every accepted response with the oldest outstanding prediction
   always @(posedge clock) begin
      bus_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $error("response with no request outstanding: read_data %h disk_dirty %b",
                   rsp_read_data, rsp_disk_dirty);
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $error("rsp_read_data: expected %h, got %h", want.read_data, rsp_read_data);
               mismatch_count++;
            end
            if (rsp_disk_dirty !== want.disk_dirty) begin
               $error("rsp_disk_dirty: expected %b, got %b", want.disk_dirty, rsp_disk_dirty);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog; CYCLE_LIMIT also covers the clearing pass after reset
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_floppy_stepper_track_controller: FAIL");
      $finish;
   end

   initial begin
      traffic_kind_type seq;
      int               n;
      int unsigned      base;
      bit               up;
      bit               pressed;
      logic [1:0]       phase;
      logic [1:0]       kind;

      mismatch_count = 0;
      items_sent     = 0;
      idle_on        = 1'b1;
      hold_request   = 1'b0;
      pressed        = 1'b0;
      wr_mode        = 1'b0;
      spindle_run    = 1'b0;
      latch_data     = '0;
      latch_loaded   = 1'b0;
      head_pos       = '0;
      phase_held     = '0;
      byte_pos       = '0;
      disk_written   = 1'b0;
      foreach (disk_image[i]) disk_image[i] = ERASED_BYTE;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_type       <= REQ_CPU_RD;
      req_addr       <= '0;
      req_write_data <= '0;
      req_image_addr <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; the clearing pass holds the first request
      foreach (directed_rows[r])
         send_request(directed_rows[r].kind, directed_rows[r].addr, directed_rows[r].data,
                      directed_rows[r].iaddr, directed_rows[r].typed,
                      directed_rows[r].exp_data, directed_rows[r].exp_dirty);

      // Random traffic, mostly well-formed sequences with random content
      while (items_sent < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 4) != 0);

         // Hold off the response side once so the pipeline fills and backs up
         if (!pressed && items_sent > RANDOM_ITEMS / 2) begin
            pressed      = 1'b1;
            idle_on      = 1'b0;
            hold_request = 1'b1;
            repeat (16) send_request(REQ_IMG_RD, 16'($urandom), 8'($urandom),
                                     IMG_W'($urandom_range(0, STORE_BYTES - 1)));
            idle_on = 1'b1;
         end

         seq = traffic_kind_type'($urandom_range(0, 5));
         case (seq)
            SEQ_STEP: begin
               bus_read(ADDR_MOTOR_ON);
               up = $urandom_range(0, 1);
               // long runs reach the end stops of the head
               n  = ($urandom_range(0, 3) == 0) ? 85 : $urandom_range(1, 10);
               repeat (n) begin
                  if ($urandom_range(0, 7) == 0) phase = 2'($urandom);
                  else phase = up ? phase_held + 2'd1 : phase_held - 2'd1;
                  bus_read(phase_addr[phase]);
               end
            end
            SEQ_WRITE: begin
               bus_write(ADDR_WMODE_ON, 8'($urandom));
               repeat ($urandom_range(1, 8)) begin
                  bus_write(ADDR_LATCH, 8'($urandom));
                  if ($urandom_range(0, 5) == 0) bus_write(ADDR_LATCH, 8'($urandom));
                  bus_read(ADDR_SHIFT);
                  if ($urandom_range(0, 5) == 0) bus_read(ADDR_SHIFT);
               end
               bus_read($urandom_range(0, 1) ? ADDR_WMODE_OFF_A : ADDR_WMODE_OFF_B);
            end
            SEQ_READ: begin
               if ($urandom_range(0, 2) == 0) bus_read(ADDR_MOTOR_OFF);
               repeat ($urandom_range(1, 12)) bus_read(ADDR_SHIFT);
            end
            SEQ_HOST: begin
               // land part of the host traffic near the start of the current track
               base = (int'(head_pos) >> 1) * TRACK_BYTES;
               repeat ($urandom_range(1, 8)) begin
                  case ($urandom_range(0, 3))
                     0: send_request(REQ_IMG_WR, 16'($urandom), 8'($urandom),
                                     IMG_W'(base + $urandom_range(0, 15)));
                     1: send_request(REQ_IMG_RD, 16'($urandom), 8'($urandom),
                                     IMG_W'(base + $urandom_range(0, 15)));
                     2: send_request(REQ_IMG_WR, 16'($urandom), 8'($urandom),
                                     IMG_W'($urandom_range(0, STORE_BYTES - 1)));
                     default: send_request(2'($urandom_range(2, 3)), 16'($urandom),
                                           8'($urandom),
                                           IMG_W'($urandom_range(STORE_BYTES, 19'h7FFFF)));
                  endcase
               end
               repeat ($urandom_range(0, 4)) bus_read(ADDR_SHIFT);
            end
            SEQ_MOTOR: begin
               bus_read(ADDR_MOTOR_OFF);
               bus_read(phase_addr[$urandom_range(0, 3)]);
               bus_read(ADDR_MOTOR_ON);
               bus_read(phase_addr[$urandom_range(0, 3)]);
            end
            default: begin
               repeat ($urandom_range(1, 6)) begin
                  kind = 2'($urandom);
                  send_request(kind,
                               ($urandom_range(0, 1) ? reg_map[$urandom_range(0, 11)]
                                                     : 16'($urandom)),
                               8'($urandom), IMG_W'($urandom));
               end
            end
         endcase
      end

      // Last part without idling: back-to-back shifts, with an occasional
      // written byte along the way
      idle_on = 1'b0;
      bus_read(ADDR_WMODE_OFF_B);
      repeat (TAIL_SHIFTS) begin
         if ($urandom_range(0, 15) == 0) begin
            bus_write(ADDR_WMODE_ON, 8'($urandom));
            bus_write(ADDR_LATCH, 8'($urandom));
            bus_read(ADDR_SHIFT);
            bus_read(ADDR_WMODE_OFF_A);
         end else begin
            bus_read(ADDR_SHIFT);
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding responses, then give the pipeline time to misbehave
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_floppy_stepper_track_controller: PASS");
      end else begin
         $display("tb_floppy_stepper_track_controller: FAIL");
      end
      $finish;
   end

endmodule

[floppy_stepper_track_controller.f]
src/fdc_pkg.sv
src/fdc_ctrl.sv
src/floppy_stepper_track_controller.sv
tb/tb_floppy_stepper_track_controller.sv
